[rtl/bre_pkg.sv]
package bre_pkg;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam logic [1:0] KIND_IDLE      = 2'd0;
   localparam logic [1:0] KIND_DISCHARGE = 2'd1;
   localparam logic [1:0] KIND_CHARGE    = 2'd2;

   localparam logic CSR_MIN_PERCENT = 1'b0;
   localparam logic CSR_MIN_MINUTES = 1'b1;

   localparam int PCT_W = 7;
   localparam int MIN_W = 16;
   localparam int EST_W = 23;
   localparam int DIV_W = 32;
   localparam int REM_W = 16;

   localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
   localparam logic [REM_W-1:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [EST_W-1:0] EST_MAX       = 23'd4194303;
   localparam logic [EST_W-1:0] EST_UNKNOWN   = 23'h7FFFFF;

   localparam logic [PCT_W-1:0] MIN_PERCENT_RESET = 7'd3;
   localparam logic [MIN_W-1:0] MIN_MINUTES_RESET = 16'd5;

endpackage

[rtl/battery_run_time_estimator.sv]
// Battery run-time estimator. Status updates classify the battery as idle,
// discharging or charging; a change of kind closes the running stretch into a
// discharge or charge ring of STRETCH_SLOTS entries (kept only if it spans at
// least the minimum percent and minutes, oldest entry overwritten when full).
// Queries return one result with counts, the running stretch and four
// estimates, each -1 when unknown. All divisions run on one shared
// bit-serial restoring divider, one quotient bit per cycle. Sequence: an
// idle or unknown-level update of the same kind is handled in the idle state;
// a kind change goes through a ring memory read then write; a same-kind
// update divides the elapsed milliseconds by 60000; a query runs four
// load-plus-divide steps and then loads the result register, plus any wait
// for the result register to drain. req_stall is high while an item is in
// progress. The ring memories are not cleared after reset; only written
// entries are ever used.
module battery_run_time_estimator
   import bre_pkg::*;
#(
   parameter int STRETCH_SLOTS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_opcode,
   input  logic [31:0]             req_time_ms,
   input  logic                    req_battery_present,
   input  logic                    req_supply_present,
   input  logic                    req_is_charging,
   input  logic signed [7:0]       req_level_percent,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [EST_W-1:0] rsp_left_minutes,
   output logic signed [EST_W-1:0] rsp_full_minutes,
   output logic signed [EST_W-1:0] rsp_life_minutes,
   output logic signed [EST_W-1:0] rsp_charge_minutes,
   output logic [4:0]              rsp_discharge_count,
   output logic [4:0]              rsp_charge_count,
   output logic [1:0]              rsp_current_kind,
   output logic [MIN_W-1:0]        rsp_current_minutes,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [MIN_W-1:0]        csr_wdata
);

   localparam int SLOT_W = (STRETCH_SLOTS > 1) ? $clog2(STRETCH_SLOTS) : 1;
   localparam int FILL_W = $clog2(STRETCH_SLOTS + 1);
   localparam int SUMP_W = $clog2(STRETCH_SLOTS * 127 + 1);
   localparam int SUMM_W = $clog2(STRETCH_SLOTS * 65535 + 1);
   localparam int ENTRY_W = PCT_W + MIN_W;
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(STRETCH_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(STRETCH_SLOTS - 1);
   localparam logic [4:0] STEP_LAST = 5'(DIV_W - 1);

   typedef enum logic [2:0] {ST_IDLE, ST_WRITE, ST_LOAD, ST_DIV, ST_DONE} state_type;
   typedef enum logic [1:0] {JOB_LEFT, JOB_FULL, JOB_LIFE, JOB_CHARGE} job_type;

   typedef struct packed {
      logic             valid;
      logic             ring;
      logic [PCT_W-1:0] span;
      logic [MIN_W-1:0] minutes;
   } offer_type;

   state_type           state_ff;
   job_type             job_ff;
   logic [4:0]          step_ff;
   logic [DIV_W-1:0]    quo_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [REM_W-1:0]    dvs_ff;
   logic                is_time_ff;

   logic [PCT_W-1:0]    min_pct_ff;
   logic [MIN_W-1:0]    min_min_ff;

   logic [1:0]          stretch_kind_ff;
   logic [PCT_W-1:0]    run_first_ff;
   logic [PCT_W-1:0]    run_latest_ff;
   logic [MIN_W-1:0]    run_elapsed_ff;
   logic [31:0]         run_start_ff;

   logic [FILL_W-1:0]   fill_ff [2];
   logic [SLOT_W-1:0]   slot_ff [2];
   logic [SUMP_W-1:0]   sump_ff [2];
   logic [SUMM_W-1:0]   summ_ff [2];
   logic [ENTRY_W-1:0]  rd_ff   [2];

   logic [ENTRY_W-1:0]  dis_mem [STRETCH_SLOTS];
   logic [ENTRY_W-1:0]  chg_mem [STRETCH_SLOTS];

   offer_type           offer_ff;
   logic [PCT_W-1:0]    q_pct_ff;
   logic                q_known_ff;
   logic [EST_W-1:0]    est_ff [4];

   logic                rsp_valid_ff;
   logic [EST_W-1:0]    rsp_left_ff;
   logic [EST_W-1:0]    rsp_full_ff;
   logic [EST_W-1:0]    rsp_life_ff;
   logic [EST_W-1:0]    rsp_charge_ff;
   logic [4:0]          rsp_dcount_ff;
   logic [4:0]          rsp_ccount_ff;
   logic [1:0]          rsp_kind_ff;
   logic [MIN_W-1:0]    rsp_minutes_ff;

   logic                accept;
   logic                known;
   logic [PCT_W-1:0]    pct_in;
   logic [1:0]          kind_in;
   logic signed [8:0]   span_dis;
   logic signed [8:0]   span_chg;
   logic signed [8:0]   span_sel;
   logic                offer_ok;

   logic [REM_W:0]      rem_shift;
   logic                take;
   logic [REM_W-1:0]    rem_in;
   logic [DIV_W-1:0]    quo_in;

   logic                job_ring;
   logic [PCT_W-1:0]    job_amount;
   logic [DIV_W-1:0]    prod_in;
   logic [EST_W-1:0]    est_in;

   logic                wr_ring;
   logic                wr_full;
   logic [ENTRY_W-1:0]  wr_old;
   logic [SUMP_W-1:0]   sump_in;
   logic [SUMM_W-1:0]   summ_in;
   logic [SLOT_W-1:0]   slot_in;
   logic [FILL_W-1:0]   fill_in;
   logic [ENTRY_W-1:0]  entry_in;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      known = !req_level_percent[7];
      if (!known) begin
         pct_in = '0;
      end else if (req_level_percent[6:0] > PCT_FULL) begin
         pct_in = PCT_FULL;
      end else begin
         pct_in = req_level_percent[6:0];
      end
      if (!req_battery_present) begin
         kind_in = KIND_IDLE;
      end else if (!req_supply_present) begin
         kind_in = KIND_DISCHARGE;
      end else if (req_is_charging) begin
         kind_in = KIND_CHARGE;
      end else begin
         kind_in = KIND_IDLE;
      end
      span_dis = $signed({2'b00, run_first_ff}) - $signed({2'b00, run_latest_ff});
      span_chg = $signed({2'b00, run_latest_ff}) - $signed({2'b00, run_first_ff});
      span_sel = (stretch_kind_ff == KIND_CHARGE) ? span_chg : span_dis;
      offer_ok = ((stretch_kind_ff == KIND_DISCHARGE) || (stretch_kind_ff == KIND_CHARGE))
                 && (span_sel >= $signed({2'b00, min_pct_ff}))
                 && (run_elapsed_ff >= min_min_ff);
   end

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      take      = (rem_shift >= {1'b0, dvs_ff});
      rem_in    = take ? REM_W'(rem_shift - {1'b0, dvs_ff}) : rem_shift[REM_W-1:0];
      quo_in    = {quo_ff[DIV_W-2:0], take};
   end

   always_comb begin
      job_ring   = (job_ff == JOB_FULL) || (job_ff == JOB_CHARGE);
      case (job_ff)
         JOB_LEFT: job_amount = q_pct_ff;
         JOB_FULL: job_amount = PCT_FULL - q_pct_ff;
         default:  job_amount = PCT_FULL;
      endcase
      prod_in = {{(DIV_W - PCT_W){1'b0}}, job_amount} * DIV_W'(summ_ff[job_ring]);
      if ((sump_ff[job_ring] == '0) || (summ_ff[job_ring] == '0) ||
          (((job_ff == JOB_LEFT) || (job_ff == JOB_FULL)) && !q_known_ff)) begin
         est_in = EST_UNKNOWN;
      end else if (quo_in > DIV_W'(EST_MAX)) begin
         est_in = EST_MAX;
      end else begin
         est_in = quo_in[EST_W-1:0];
      end
   end

   always_comb begin
      wr_ring  = offer_ff.ring;
      wr_full  = (fill_ff[wr_ring] >= FILL_FULL);
      wr_old   = rd_ff[wr_ring];
      sump_in  = sump_ff[wr_ring] - (wr_full ? SUMP_W'(wr_old[PCT_W-1:0]) : SUMP_W'(0))
                 + SUMP_W'(offer_ff.span);
      summ_in  = summ_ff[wr_ring] - (wr_full ? SUMM_W'(wr_old[ENTRY_W-1:PCT_W]) : SUMM_W'(0))
                 + SUMM_W'(offer_ff.minutes);
      slot_in  = (slot_ff[wr_ring] == SLOT_LAST) ? '0 : slot_ff[wr_ring] + SLOT_W'(1);
      fill_in  = wr_full ? fill_ff[wr_ring] : fill_ff[wr_ring] + FILL_W'(1);
      entry_in = {offer_ff.minutes, offer_ff.span};
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_WRITE) && offer_ff.valid && !offer_ff.ring) begin
         dis_mem[slot_ff[0]] <= entry_in;
      end
      rd_ff[0] <= dis_mem[slot_ff[0]];
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_WRITE) && offer_ff.valid && offer_ff.ring) begin
         chg_mem[slot_ff[1]] <= entry_in;
      end
      rd_ff[1] <= chg_mem[slot_ff[1]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         job_ff          <= JOB_LEFT;
         step_ff         <= '0;
         is_time_ff      <= 1'b0;
         min_pct_ff      <= MIN_PERCENT_RESET;
         min_min_ff      <= MIN_MINUTES_RESET;
         stretch_kind_ff <= KIND_IDLE;
         run_first_ff    <= '0;
         run_latest_ff   <= '0;
         run_elapsed_ff  <= '0;
         run_start_ff    <= '0;
         for (int r = 0; r < 2; r++) begin
            fill_ff[r] <= '0;
            slot_ff[r] <= '0;
            sump_ff[r] <= '0;
            summ_ff[r] <= '0;
         end
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MIN_PERCENT) begin
               min_pct_ff <= csr_wdata[PCT_W-1:0];
            end else begin
               min_min_ff <= csr_wdata;
            end
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_opcode == OP_QUERY) begin
                     q_pct_ff   <= pct_in;
                     q_known_ff <= known;
                     job_ff     <= JOB_LEFT;
                     state_ff   <= ST_LOAD;
                  end else if (kind_in != stretch_kind_ff) begin
                     offer_ff.valid   <= offer_ok;
                     offer_ff.ring    <= (stretch_kind_ff == KIND_CHARGE);
                     offer_ff.span    <= span_sel[PCT_W-1:0];
                     offer_ff.minutes <= run_elapsed_ff;
                     stretch_kind_ff  <= kind_in;
                     run_first_ff     <= pct_in;
                     run_latest_ff    <= pct_in;
                     run_elapsed_ff   <= '0;
                     run_start_ff     <= req_time_ms;
                     state_ff         <= ST_WRITE;
                  end else if ((kind_in != KIND_IDLE) && known) begin
                     run_latest_ff <= pct_in;
                     quo_ff        <= req_time_ms - run_start_ff;
                     rem_ff        <= '0;
                     dvs_ff        <= MS_PER_MINUTE;
                     step_ff       <= '0;
                     is_time_ff    <= 1'b1;
                     state_ff      <= ST_DIV;
                  end
               end
            end
            ST_WRITE: begin
               if (offer_ff.valid) begin
                  fill_ff[wr_ring] <= fill_in;
                  slot_ff[wr_ring] <= slot_in;
                  sump_ff[wr_ring] <= sump_in;
                  summ_ff[wr_ring] <= summ_in;
               end
               state_ff <= ST_IDLE;
            end
            ST_LOAD: begin
               quo_ff     <= prod_in;
               rem_ff     <= '0;
               dvs_ff     <= REM_W'(sump_ff[job_ring]);
               step_ff    <= '0;
               is_time_ff <= 1'b0;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               quo_ff  <= quo_in;
               rem_ff  <= rem_in;
               step_ff <= step_ff + 5'd1;
               if (step_ff == STEP_LAST) begin
                  if (is_time_ff) begin
                     run_elapsed_ff <= quo_in[MIN_W-1:0];
                     state_ff       <= ST_IDLE;
                  end else begin
                     est_ff[job_ff] <= est_in;
                     if (job_ff == JOB_CHARGE) begin
                        state_ff <= ST_DONE;
                     end else begin
                        job_ff   <= job_type'(job_ff + 2'd1);
                        state_ff <= ST_LOAD;
                     end
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_left_ff    <= est_ff[JOB_LEFT];
                  rsp_full_ff    <= est_ff[JOB_FULL];
                  rsp_life_ff    <= est_ff[JOB_LIFE];
                  rsp_charge_ff  <= est_ff[JOB_CHARGE];
                  rsp_dcount_ff  <= 5'(fill_ff[0]);
                  rsp_ccount_ff  <= 5'(fill_ff[1]);
                  rsp_kind_ff    <= stretch_kind_ff;
                  rsp_minutes_ff <= run_elapsed_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_minutes    = $signed(rsp_left_ff);
   assign rsp_full_minutes    = $signed(rsp_full_ff);
   assign rsp_life_minutes    = $signed(rsp_life_ff);
   assign rsp_charge_minutes  = $signed(rsp_charge_ff);
   assign rsp_discharge_count = rsp_dcount_ff;
   assign rsp_charge_count    = rsp_ccount_ff;
   assign rsp_current_kind    = rsp_kind_ff;
   assign rsp_current_minutes = rsp_minutes_ff;

endmodule

[rtl/bre_checker.sv]
module bre_checker
   import bre_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_opcode,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [EST_W-1:0] rsp_left_minutes,
   input logic signed [EST_W-1:0] rsp_full_minutes,
   input logic signed [EST_W-1:0] rsp_life_minutes,
   input logic signed [EST_W-1:0] rsp_charge_minutes,
   input logic [MIN_W-1:0]        rsp_current_minutes
);

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_QUERY) |=> req_stall)
      else $error("query transfer did not hold off the next request");

   a_update_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_UPDATE) && !rsp_valid |=> !rsp_valid)
      else $error("update transfer produced a response");

   a_left_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_life_minutes == '1) |-> (rsp_left_minutes == '1))
      else $error("left estimate known while discharge history is empty");

   a_full_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_charge_minutes == '1) |-> (rsp_full_minutes == '1))
      else $error("full estimate known while charge history is empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_minutes)
                                 && $stable(rsp_current_minutes))
      else $error("stalled response changed");

endmodule

bind battery_run_time_estimator bre_checker u_bre_checker (.*);

[verif/tb_top.sv]
module tb_top;
   import bre_pkg::*;

   localparam int SLOTS         = 16;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 64;
   localparam int FINAL_CYCLES  = 200;
   localparam int HOLD_CYCLES   = 1500;
   localparam int RING_DIS      = 0;
   localparam int RING_CHG      = 1;
   localparam logic [31:0] LONG_STRETCH_MS = 32'd3932100000;

   typedef struct {
      logic              opcode;
      logic [31:0]       time_ms;
      logic              battery_present;
      logic              supply_present;
      logic              is_charging;
      logic signed [7:0] level_percent;
   } reading_type;

   typedef struct {
      logic signed [EST_W-1:0] left_minutes;
      logic signed [EST_W-1:0] full_minutes;
      logic signed [EST_W-1:0] life_minutes;
      logic signed [EST_W-1:0] charge_minutes;
      logic [4:0]              discharge_count;
      logic [4:0]              charge_count;
      logic [1:0]              current_kind;
      logic [MIN_W-1:0]        current_minutes;
   } answer_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_opcode;
   logic [31:0]             req_time_ms;
   logic                    req_battery_present;
   logic                    req_supply_present;
   logic                    req_is_charging;
   logic signed [7:0]       req_level_percent;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [EST_W-1:0] rsp_left_minutes;
   logic signed [EST_W-1:0] rsp_full_minutes;
   logic signed [EST_W-1:0] rsp_life_minutes;
   logic signed [EST_W-1:0] rsp_charge_minutes;
   logic [4:0]              rsp_discharge_count;
   logic [4:0]              rsp_charge_count;
   logic [1:0]              rsp_current_kind;
   logic [MIN_W-1:0]        rsp_current_minutes;
   logic                    csr_we;
   logic                    csr_index;
   logic [MIN_W-1:0]        csr_wdata;

   // predicted block state
   logic [EST_W-1:0] ring_mem [2][SLOTS];
   int               ring_fill [2];
   int               ring_slot [2];
   int               sum_pct [2];
   int               sum_min [2];
   logic [PCT_W-1:0] min_pct;
   logic [MIN_W-1:0] min_min;
   logic [1:0]       stretch_kind;
   int               run_first;
   int               run_latest;
   logic [MIN_W-1:0] run_elapsed;
   logic [31:0]      run_start;

   answer_type  answers_due [$];
   int          errors = 0;
   int          cycles = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   int          random_sent = 0;
   bit          gaps_on = 1'b1;
   logic [31:0] now_ms = '0;

   battery_run_time_estimator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_time_ms         (req_time_ms),
      .req_battery_present (req_battery_present),
      .req_supply_present  (req_supply_present),
      .req_is_charging     (req_is_charging),
      .req_level_percent   (req_level_percent),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_left_minutes    (rsp_left_minutes),
      .rsp_full_minutes    (rsp_full_minutes),
      .rsp_life_minutes    (rsp_life_minutes),
      .rsp_charge_minutes  (rsp_charge_minutes),
      .rsp_discharge_count (rsp_discharge_count),
      .rsp_charge_count    (rsp_charge_count),
      .rsp_current_kind    (rsp_current_kind),
      .rsp_current_minutes (rsp_current_minutes),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void reset_estimator();
      for (int r = 0; r < 2; r++) begin
         ring_fill[r] = 0;
         ring_slot[r] = 0;
         sum_pct[r]   = 0;
         sum_min[r]   = 0;
      end
      min_pct      = MIN_PERCENT_RESET;
      min_min      = MIN_MINUTES_RESET;
      stretch_kind = KIND_IDLE;
      run_first    = 0;
      run_latest   = 0;
      run_elapsed  = '0;
      run_start    = '0;
   endfunction

   function automatic void log_stretch(int r, int span, int minutes);
      int s;
      s = ring_slot[r];
      if (span < int'(min_pct) || minutes < int'(min_min)) return;
      if (ring_fill[r] >= SLOTS) begin
         sum_pct[r] -= int'(ring_mem[r][s][PCT_W-1:0]);
         sum_min[r] -= int'(ring_mem[r][s][EST_W-1:PCT_W]);
      end
      ring_mem[r][s] = {minutes[MIN_W-1:0], span[PCT_W-1:0]};
      sum_pct[r] += int'(span[PCT_W-1:0]);
      sum_min[r] += int'(minutes[MIN_W-1:0]);
      ring_slot[r] = (s + 1) % SLOTS;
      if (ring_fill[r] < SLOTS) ring_fill[r]++;
   endfunction

   function automatic logic [EST_W-1:0] ring_estimate(int r, int amount);
      longint q;
      if (sum_pct[r] == 0 || sum_min[r] == 0) return EST_UNKNOWN;
      q = longint'(amount) * longint'(sum_min[r]) / longint'(sum_pct[r]);
      if (q > longint'(EST_MAX)) q = longint'(EST_MAX);
      return q[EST_W-1:0];
   endfunction

   function automatic void apply_reading(reading_type rd);
      int          lvl;
      int          pct;
      bit          known;
      logic [1:0]  kind;
      logic [31:0] mins;
      answer_type  ans;
      lvl   = int'(rd.level_percent);
      known = lvl >= 0;
      pct   = !known ? 0 : (lvl > 100 ? 100 : lvl);
      if (rd.opcode == OP_UPDATE) begin
         if (!rd.battery_present) kind = KIND_IDLE;
         else if (!rd.supply_present) kind = KIND_DISCHARGE;
         else if (rd.is_charging) kind = KIND_CHARGE;
         else kind = KIND_IDLE;
         if (kind != stretch_kind) begin
            if (stretch_kind == KIND_DISCHARGE) begin
               log_stretch(RING_DIS, run_first - run_latest, int'(run_elapsed));
            end else if (stretch_kind == KIND_CHARGE) begin
               log_stretch(RING_CHG, run_latest - run_first, int'(run_elapsed));
            end
            stretch_kind = kind;
            run_first    = pct;
            run_latest   = pct;
            run_elapsed  = '0;
            run_start    = rd.time_ms;
         end else if (kind != KIND_IDLE && known) begin
            run_latest  = pct;
            mins        = (rd.time_ms - run_start) / 32'(MS_PER_MINUTE);
            run_elapsed = mins[MIN_W-1:0];
         end
      end else begin
         ans.left_minutes    = known ? ring_estimate(RING_DIS, pct) : EST_UNKNOWN;
         ans.full_minutes    = known ? ring_estimate(RING_CHG, 100 - pct) : EST_UNKNOWN;
         ans.life_minutes    = ring_estimate(RING_DIS, 100);
         ans.charge_minutes  = ring_estimate(RING_CHG, 100);
         ans.discharge_count = 5'(ring_fill[RING_DIS]);
         ans.charge_count    = 5'(ring_fill[RING_CHG]);
         ans.current_kind    = stretch_kind;
         ans.current_minutes = run_elapsed;
         answers_due.push_back(ans);
      end
   endfunction

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   function automatic reading_type make_update(logic [1:0] kind, int level);
      reading_type rd;
      rd.opcode        = OP_UPDATE;
      rd.time_ms       = now_ms;
      rd.level_percent = 8'(level);
      case (kind)
         KIND_DISCHARGE: begin
            rd.battery_present = 1'b1;
            rd.supply_present  = 1'b0;
            rd.is_charging     = 1'($urandom);
         end
         KIND_CHARGE: begin
            rd.battery_present = 1'b1;
            rd.supply_present  = 1'b1;
            rd.is_charging     = 1'b1;
         end
         default: begin
            if ($urandom_range(0, 1) == 0) begin
               rd.battery_present = 1'b0;
               rd.supply_present  = 1'($urandom);
               rd.is_charging     = 1'($urandom);
            end else begin
               rd.battery_present = 1'b1;
               rd.supply_present  = 1'b1;
               rd.is_charging     = 1'b0;
            end
         end
      endcase
      return rd;
   endfunction

   function automatic reading_type make_query(int level);
      reading_type rd;
      rd.opcode          = OP_QUERY;
      rd.time_ms         = $urandom();
      rd.battery_present = 1'($urandom);
      rd.supply_present  = 1'($urandom);
      rd.is_charging     = 1'($urandom);
      rd.level_percent   = 8'(level);
      return rd;
   endfunction

   function automatic reading_type make_noise();
      reading_type rd;
      rd.opcode          = 1'($urandom);
      rd.time_ms         = $urandom();
      rd.battery_present = 1'($urandom);
      rd.supply_present  = 1'($urandom);
      rd.is_charging     = 1'($urandom);
      rd.level_percent   = 8'($urandom);
      return rd;
   endfunction

   function automatic logic [31:0] step_ms();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 32'($urandom_range(0, 12)) * 32'd60000 + 32'($urandom_range(0, 59999));
      if (r < 95) return 32'($urandom_range(13, 3000)) * 32'd60000 + 32'($urandom_range(0, 59999));
      return $urandom();
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      if (errors <= 100) $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic send_reading(reading_type rd);
      @(negedge clock);
      req_opcode          <= rd.opcode;
      req_time_ms         <= rd.time_ms;
      req_battery_present <= rd.battery_present;
      req_supply_present  <= rd.supply_present;
      req_is_charging     <= rd.is_charging;
      req_level_percent   <= rd.level_percent;
      req_valid           <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_reading(rd);
   endtask

   task automatic pause_sender(int n);
      if (n == 0) return;
      @(negedge clock);
      req_valid           <= 1'b0;
      req_opcode          <= 1'($urandom);
      req_time_ms         <= $urandom();
      req_battery_present <= 1'($urandom);
      req_supply_present  <= 1'($urandom);
      req_is_charging     <= 1'($urandom);
      req_level_percent   <= 8'($urandom);
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_spaced(reading_type rd);
      send_reading(rd);
      pause_sender(random_gap());
   endtask

   task automatic settle();
      pause_sender(1);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [MIN_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_MIN_PERCENT) min_pct = value[PCT_W-1:0];
      else min_min = value;
   endtask

   task automatic configure(int pct, int mins);
      settle();
      write_csr(CSR_MIN_PERCENT, {9'($urandom), 7'(pct)});
      write_csr(CSR_MIN_MINUTES, 16'(mins));
   endtask

   task automatic test_empty_query();
      send_spaced(make_query(0));
      send_spaced(make_query(100));
      send_spaced(make_query(-1));
   endtask

   task automatic test_level_extremes();
      now_ms = 32'h0000_1000;
      send_spaced(make_update(KIND_DISCHARGE, 127));
      now_ms += 32'd7 * 32'd60000;
      send_spaced(make_update(KIND_DISCHARGE, -128));
      now_ms += 32'd60000;
      send_spaced(make_update(KIND_DISCHARGE, -1));
      send_spaced(make_update(KIND_DISCHARGE, 90));
      send_spaced(make_query(101));
      send_spaced(make_update(KIND_CHARGE, 20));
      now_ms += 32'd4 * 32'd60000;
      send_spaced(make_update(KIND_CHARGE, 100));
      send_spaced(make_update(KIND_IDLE, 100));
      send_spaced(make_update(KIND_IDLE, 50));
      send_spaced(make_query(-128));
      send_spaced(make_query(0));
   endtask

   task automatic test_time_wrap();
      now_ms = 32'hFFFF_0000;
      send_spaced(make_update(KIND_DISCHARGE, 80));
      now_ms += 32'd12 * 32'd60000;
      send_spaced(make_update(KIND_DISCHARGE, 78));
      send_spaced(make_query(78));
      now_ms += 32'd4000000000;
      send_spaced(make_update(KIND_DISCHARGE, 60));
      send_spaced(make_query(60));
      send_spaced(make_update(KIND_IDLE, 60));
   endtask

   task automatic test_saturation();
      configure(1, 0);
      now_ms += 32'd60000;
      send_spaced(make_update(KIND_CHARGE, 50));
      now_ms += LONG_STRETCH_MS;
      send_spaced(make_update(KIND_CHARGE, 51));
      send_spaced(make_update(KIND_IDLE, 51));
      send_spaced(make_query(0));
      send_spaced(make_query(100));
   endtask

   task automatic test_backpressure();
      int n;
      hold_left = HOLD_CYCLES;
      for (n = 0; n < 6; n++) send_reading(make_query($urandom_range(0, 100)));
      pause_sender(1);
   endtask

   task automatic run_stretch();
      logic [1:0] kind;
      int         level;
      int         steps;
      int         r;
      kind  = ($urandom_range(0, 1) == 0) ? KIND_DISCHARGE : KIND_CHARGE;
      level = (kind == KIND_CHARGE) ? $urandom_range(0, 60) : $urandom_range(40, 100);
      send_spaced(make_update(kind, level));
      random_sent++;
      steps = $urandom_range(1, 6);
      repeat (steps) begin
         now_ms += step_ms();
         if (kind == KIND_CHARGE) level = level + int'($urandom_range(0, 15));
         else level = level - int'($urandom_range(0, 15));
         if (level > 100) level = 100;
         if (level < 0) level = 0;
         r = $urandom_range(0, 9);
         if (r == 0) send_spaced(make_update(kind, -int'($urandom_range(1, 128))));
         else if (r == 1 && level == 100) send_spaced(make_update(kind, $urandom_range(101, 127)));
         else send_spaced(make_update(kind, level));
         random_sent++;
         if ($urandom_range(0, 4) == 0) begin
            send_spaced(make_query($urandom_range(0, 100)));
            random_sent++;
         end
      end
      now_ms += step_ms();
      r = $urandom_range(0, 3);
      if (r == 0) begin
         send_spaced(make_update(kind == KIND_CHARGE ? KIND_DISCHARGE : KIND_CHARGE, level));
         random_sent++;
      end else if (r != 1) begin
         send_spaced(make_update(KIND_IDLE, $urandom_range(0, 255)));
         random_sent++;
      end
   endtask

   task automatic run_random(int n);
      int pick;
      random_sent = 0;
      while (random_sent < n) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            send_spaced(make_noise());
            random_sent++;
         end else if (pick <= 2) begin
            if ($urandom_range(0, 4) == 0) send_spaced(make_query($urandom_range(0, 255)));
            else send_spaced(make_query($urandom_range(0, 100)));
            random_sent++;
         end else begin
            run_stretch();
         end
      end
   endtask

   task automatic test_random_phases();
      int pct_set [8] = '{3, 0, 1, 100, 0, 127, 2, 50};
      int min_set [8] = '{5, 0, 1, 0, 65535, 0, 3, 10};
      for (int p = 0; p < 8; p++) begin
         if (p == 6) begin
            pct_set[p] = $urandom_range(0, 10);
            min_set[p] = $urandom_range(0, 30);
         end
         configure(pct_set[p], min_set[p]);
         gaps_on = (p % 3) != 2;
         run_random(100);
         gaps_on = 1'b1;
      end
   endtask

   task automatic check_answer();
      answer_type want;
      if (answers_due.size() == 0) begin
         report_mismatch("result with none expected", 0, 0);
         return;
      end
      want = answers_due.pop_front();
      if (rsp_left_minutes !== want.left_minutes)
         report_mismatch("left_minutes", rsp_left_minutes, want.left_minutes);
      if (rsp_full_minutes !== want.full_minutes)
         report_mismatch("full_minutes", rsp_full_minutes, want.full_minutes);
      if (rsp_life_minutes !== want.life_minutes)
         report_mismatch("life_minutes", rsp_life_minutes, want.life_minutes);
      if (rsp_charge_minutes !== want.charge_minutes)
         report_mismatch("charge_minutes", rsp_charge_minutes, want.charge_minutes);
      if (rsp_discharge_count !== want.discharge_count)
         report_mismatch("discharge_count", rsp_discharge_count, want.discharge_count);
      if (rsp_charge_count !== want.charge_count)
         report_mismatch("charge_count", rsp_charge_count, want.charge_count);
      if (rsp_current_kind !== want.current_kind)
         report_mismatch("current_kind", rsp_current_kind, want.current_kind);
      if (rsp_current_minutes !== want.current_minutes)
         report_mismatch("current_minutes", rsp_current_minutes, want.current_minutes);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_answer();
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = random_gap();
         end
      end
   end

   initial begin
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_opcode          = OP_UPDATE;
      req_time_ms         = '0;
      req_battery_present = 1'b0;
      req_supply_present  = 1'b0;
      req_is_charging     = 1'b0;
      req_level_percent   = '0;
      csr_we              = 1'b0;
      csr_index           = CSR_MIN_PERCENT;
      csr_wdata           = '0;
      reset_estimator();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_query();
      test_level_extremes();
      test_time_wrap();
      test_saturation();
      test_backpressure();
      test_random_phases();
      settle();
      repeat (FINAL_CYCLES) @(posedge clock);
      if (answers_due.size() != 0) report_mismatch("results never delivered", answers_due.size(), 0);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
